/* hw/rtl/pdc_pkg.sv */
// pdc_pkg: shared types and constants for the pulse discriminator and charge unit
// item structs, configuration struct, register indexes and width constants
// no dependencies
package pdc_pkg;

   // widths
   localparam int SAMPLE_BITS     = 16;
   localparam int CHARGE_BITS     = 48;
   localparam int TIME_BITS       = 32;
   localparam int WINDOW_BITS     = 20;
   localparam int CHARGE_OUT_BITS = 48;
   localparam int COUNT_BITS      = 32;
   localparam int CSR_INDEX_BITS  = 3;
   localparam int CSR_DATA_BITS   = 32;

   // charge limits
   localparam logic signed [CHARGE_BITS-1:0] CHARGE_MAX = {1'b0, {(CHARGE_BITS-1){1'b1}}};
   localparam logic signed [CHARGE_BITS-1:0] CHARGE_MIN = {1'b1, {(CHARGE_BITS-1){1'b0}}};

   // register reset values
   localparam logic signed [SAMPLE_BITS-1:0] BASELINE_RST   = SAMPLE_BITS'(0);
   localparam logic signed [SAMPLE_BITS-1:0] SINGLE_THR_RST = SAMPLE_BITS'(-100);
   localparam logic signed [SAMPLE_BITS-1:0] LOW_THR_RST    = SAMPLE_BITS'(-30);
   localparam logic signed [SAMPLE_BITS-1:0] HIGH_THR_RST   = SAMPLE_BITS'(-100);
   localparam logic [WINDOW_BITS-1:0]        WINDOW_RST     = WINDOW_BITS'(10000);
   localparam logic signed [TIME_BITS-1:0]   GATE_START_RST = TIME_BITS'(-200000);

   // register indexes
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_BASELINE    = 3'd0,
      CSR_SINGLE_THR  = 3'd1,
      CSR_LOW_THR     = 3'd2,
      CSR_HIGH_THR    = 3'd3,
      CSR_WINDOW      = 3'd4,
      CSR_GATE_START  = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] baseline;
      logic signed [SAMPLE_BITS-1:0] single_threshold;
      logic signed [SAMPLE_BITS-1:0] low_threshold;
      logic signed [SAMPLE_BITS-1:0] high_threshold;
      logic [WINDOW_BITS-1:0]        coincidence_window;
      logic signed [TIME_BITS-1:0]   gate_start;
   } cfg_type;

   typedef struct packed {
      logic signed [TIME_BITS-1:0]   sample_time;
      logic signed [SAMPLE_BITS-1:0] sample_value;
      logic                          last_sample;
   } req_type;

   typedef struct packed {
      logic                              single_hit;
      logic signed [TIME_BITS-1:0]       single_time;
      logic                              double_hit;
      logic signed [TIME_BITS-1:0]       double_time;
      logic signed [CHARGE_OUT_BITS-1:0] charge;
      logic [COUNT_BITS-1:0]             waveform_count;
      logic [COUNT_BITS-1:0]             hit_count;
   } rsp_type;

endpackage

/* hw/rtl/pulse_discriminator_and_charge_unit.sv */
// pulse_discriminator_and_charge_unit: top level of the sample discriminator
// depends on pdc_pkg, pdc_csr and pdc_core
//
// Usage:
//  - req channel (req_valid, req_stall, req_data) takes one timestamped sample
//    per item; req_data.last_sample marks the end of a waveform.
//  - rsp channel (rsp_valid, rsp_stall, rsp_data) returns one item per waveform
//    with hit flags, crossing times, negated charge and running counts.
//  - csr channel (csr_valid, csr_ready, csr_index, csr_wdata) writes the six
//    registers; csr_ready is always high. Write only while the block is idle.
//  - throughput: one sample per clock while req_stall is low. An accepted item
//    waits in the input register while the discriminator state updates; the
//    result of a last sample is then registered in the output register.
//  - stall: the output register holds a result while rsp_stall is high; other
//    samples keep flowing. Only a last sample that finds the output register
//    still full waits, and then req_stall is raised.
//  - reset (synchronous) restores register defaults, clears waveform state,
//    counters and the valid flags of both pipeline registers.
module pulse_discriminator_and_charge_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  pdc_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output pdc_pkg::rsp_type                   rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [pdc_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [pdc_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   pdc_pkg::cfg_type cfg;
   pdc_pkg::rsp_type result;
   pdc_pkg::req_type in_item_ff, in_item_in;
   pdc_pkg::rsp_type out_item_ff, out_item_in;
   logic             in_valid_ff, in_valid_in;
   logic             out_valid_ff, out_valid_in;
   logic             out_free, advance, fire, req_take;

   assign csr_ready = 1'b1;

   pdc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   pdc_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (in_item_ff),
      .cfg    (cfg),
      .result (result)
   );

   // flow control: only a last item needs room in the output register
   always_comb begin
      out_free  = !out_valid_ff || !rsp_stall;
      advance   = !in_item_ff.last_sample || out_free;
      fire      = in_valid_ff && advance;
      req_stall = in_valid_ff && !advance;
      req_take  = req_valid && !req_stall;
   end

   // input register next state
   always_comb begin
      in_item_in  = req_take ? req_data : in_item_ff;
      in_valid_in = req_take | (in_valid_ff & ~fire);
   end

   // output register next state
   always_comb begin
      out_item_in  = out_item_ff;
      out_valid_in = out_valid_ff & rsp_stall;
      if (fire && in_item_ff.last_sample) begin
         out_item_in  = result;
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff  <= in_item_in;
      out_item_ff <= out_item_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_item_ff;

   // a processed last item always lands in the output register
   a_last_to_out: assert property (@(posedge clock) disable iff (reset)
      fire && in_item_ff.last_sample |=> out_valid_ff)
      else $error("last item did not produce a result");

   // input side only waits behind a full, stalled output register
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && in_item_ff.last_sample && out_valid_ff && rsp_stall)
      else $error("input stalled without cause");

   // times read as zero without a hit
   a_single_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.single_hit |-> rsp_data.single_time == '0)
      else $error("single time set without hit");

   a_double_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.double_hit |-> rsp_data.double_time == '0)
      else $error("double time set without hit");

endmodule

/* hw/rtl/pdc_csr.sv */
// pdc_csr: configuration register file of the pulse discriminator
// depends on pdc_pkg; writes to unknown indexes are dropped
module pdc_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   input  logic [pdc_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [pdc_pkg::CSR_DATA_BITS-1:0]    csr_wdata,
   output pdc_pkg::cfg_type                     cfg
);

   pdc_pkg::cfg_type cfg_ff, cfg_in;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            pdc_pkg::CSR_BASELINE:
               cfg_in.baseline = csr_wdata[pdc_pkg::SAMPLE_BITS-1:0];
            pdc_pkg::CSR_SINGLE_THR:
               cfg_in.single_threshold = csr_wdata[pdc_pkg::SAMPLE_BITS-1:0];
            pdc_pkg::CSR_LOW_THR:
               cfg_in.low_threshold = csr_wdata[pdc_pkg::SAMPLE_BITS-1:0];
            pdc_pkg::CSR_HIGH_THR:
               cfg_in.high_threshold = csr_wdata[pdc_pkg::SAMPLE_BITS-1:0];
            pdc_pkg::CSR_WINDOW:
               cfg_in.coincidence_window = csr_wdata[pdc_pkg::WINDOW_BITS-1:0];
            pdc_pkg::CSR_GATE_START:
               cfg_in.gate_start = csr_wdata[pdc_pkg::TIME_BITS-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   // registers with reset values
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.baseline           <= pdc_pkg::BASELINE_RST;
         cfg_ff.single_threshold   <= pdc_pkg::SINGLE_THR_RST;
         cfg_ff.low_threshold      <= pdc_pkg::LOW_THR_RST;
         cfg_ff.high_threshold     <= pdc_pkg::HIGH_THR_RST;
         cfg_ff.coincidence_window <= pdc_pkg::WINDOW_RST;
         cfg_ff.gate_start         <= pdc_pkg::GATE_START_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* hw/rtl/pdc_core.sv */
// pdc_core: per-waveform discriminator state, charge accumulator and counters
// depends on pdc_pkg; updates state once per processed item
module pdc_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              fire,
   input  pdc_pkg::req_type  item,
   input  pdc_pkg::cfg_type  cfg,
   output pdc_pkg::rsp_type  result
);

   logic                                   single_seen_ff, single_seen_in;
   logic signed [pdc_pkg::TIME_BITS-1:0]   single_time_ff, single_time_in;
   logic                                   low_seen_ff, low_seen_in;
   logic signed [pdc_pkg::TIME_BITS-1:0]   low_time_ff, low_time_in;
   logic                                   high_seen_ff, high_seen_in;
   logic signed [pdc_pkg::CHARGE_BITS-1:0] charge_ff, charge_in;
   logic [pdc_pkg::COUNT_BITS-1:0]         waves_ff, waves_in;
   logic [pdc_pkg::COUNT_BITS-1:0]         hits_ff, hits_in;

   logic signed [pdc_pkg::SAMPLE_BITS:0]   corr;
   logic                                   single_nx, low_nx, high_nx;
   logic signed [pdc_pkg::TIME_BITS-1:0]   single_t_nx, low_t_nx;
   logic signed [pdc_pkg::TIME_BITS:0]     dt;
   logic                                   win_ok;
   logic signed [pdc_pkg::CHARGE_BITS:0]   sum_wide;
   logic signed [pdc_pkg::CHARGE_BITS-1:0] sum_sat, charge_nx, neg;
   logic signed [63:0]                     neg_ext;
   logic [pdc_pkg::COUNT_BITS-1:0]         waves_nx, hits_nx;

   // baseline correction, discriminators and charge accumulation
   always_comb begin
      corr = (pdc_pkg::SAMPLE_BITS+1)'(item.sample_value)
             - (pdc_pkg::SAMPLE_BITS+1)'(cfg.baseline);

      single_nx   = single_seen_ff | (corr <= cfg.single_threshold);
      single_t_nx = single_seen_ff ? single_time_ff : item.sample_time;

      low_nx   = low_seen_ff | (corr <= cfg.low_threshold);
      low_t_nx = low_seen_ff ? low_time_ff : item.sample_time;

      // window test uses the arming time, possibly set by this same item
      dt      = (pdc_pkg::TIME_BITS+1)'(item.sample_time)
                - (pdc_pkg::TIME_BITS+1)'(low_t_nx);
      win_ok  = dt <= $signed({1'b0, cfg.coincidence_window});
      high_nx = high_seen_ff | (low_nx & (corr <= cfg.high_threshold) & win_ok);

      // saturating add of the gated sample
      sum_wide = (pdc_pkg::CHARGE_BITS+1)'(charge_ff) + (pdc_pkg::CHARGE_BITS+1)'(corr);
      if (sum_wide[pdc_pkg::CHARGE_BITS] != sum_wide[pdc_pkg::CHARGE_BITS-1]) begin
         sum_sat = sum_wide[pdc_pkg::CHARGE_BITS] ? pdc_pkg::CHARGE_MIN : pdc_pkg::CHARGE_MAX;
      end else begin
         sum_sat = sum_wide[pdc_pkg::CHARGE_BITS-1:0];
      end
      charge_nx = (item.sample_time >= cfg.gate_start) ? sum_sat : charge_ff;

      // clamped negation
      neg     = (charge_nx == pdc_pkg::CHARGE_MIN) ? pdc_pkg::CHARGE_MAX : -charge_nx;
      neg_ext = 64'(neg);

      waves_nx = waves_ff + 1'b1;
      hits_nx  = single_nx ? hits_ff + 1'b1 : hits_ff;
   end

   // result fields for a last item
   always_comb begin
      result.single_hit     = single_nx;
      result.single_time    = single_nx ? single_t_nx : '0;
      result.double_hit     = high_nx;
      result.double_time    = high_nx ? low_t_nx : '0;
      result.charge         = neg_ext[pdc_pkg::CHARGE_OUT_BITS-1:0];
      result.waveform_count = waves_nx;
      result.hit_count      = hits_nx;
   end

   // next state: keep, update, or at end of waveform clear the waveform state and advance the counters
   always_comb begin
      single_seen_in = single_seen_ff;
      single_time_in = single_time_ff;
      low_seen_in    = low_seen_ff;
      low_time_in    = low_time_ff;
      high_seen_in   = high_seen_ff;
      charge_in      = charge_ff;
      waves_in       = waves_ff;
      hits_in        = hits_ff;
      if (fire) begin
         if (item.last_sample) begin
            single_seen_in = 1'b0;
            single_time_in = '0;
            low_seen_in    = 1'b0;
            low_time_in    = '0;
            high_seen_in   = 1'b0;
            charge_in      = '0;
            waves_in       = waves_nx;
            hits_in        = hits_nx;
         end else begin
            single_seen_in = single_nx;
            single_time_in = single_t_nx;
            low_seen_in    = low_nx;
            low_time_in    = low_t_nx;
            high_seen_in   = high_nx;
            charge_in      = charge_nx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         single_seen_ff <= 1'b0;
         single_time_ff <= '0;
         low_seen_ff    <= 1'b0;
         low_time_ff    <= '0;
         high_seen_ff   <= 1'b0;
         charge_ff      <= '0;
         waves_ff       <= '0;
         hits_ff        <= '0;
      end else begin
         single_seen_ff <= single_seen_in;
         single_time_ff <= single_time_in;
         low_seen_ff    <= low_seen_in;
         low_time_ff    <= low_time_in;
         high_seen_ff   <= high_seen_in;
         charge_ff      <= charge_in;
         waves_ff       <= waves_in;
         hits_ff        <= hits_in;
      end
   end

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 100ps
// tb_top: self-checking bench for pulse_discriminator_and_charge_unit
// depends on pdc_pkg and the unit; predicts every waveform summary and checks it
module tb_top;
   import pdc_pkg::*;

   localparam int      CLK_HALF        = 6;
   localparam int      RESET_CYCLES    = 6;
   localparam int      PHASES          = 9;
   localparam int      ITEMS_PER_PHASE = 103;
   localparam int      HOLD_CYCLES     = 80;
   localparam int      SETTLE_CYCLES   = 4;
   localparam int      DRAIN_LIMIT     = 20000;
   localparam int      PRINT_LIMIT     = 50;
   localparam longint  TIMEOUT_CYCLES  = 200000;

   // indexes outside the register map
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_A = 3'd6;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_B = 3'd7;

   typedef enum int {PACE_SLOW_RX, PACE_SLOW_TX, PACE_FULL} pace_type;
   typedef enum logic {ROW_SAMPLE, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type              kind;
      req_type                   sample;
      bit                        checked;
      rsp_type                   want;
      logic [CSR_INDEX_BITS-1:0] csr_idx;
      logic [CSR_DATA_BITS-1:0]  csr_val;
   } dir_row_type;

   typedef struct {
      bit                            single_seen;
      logic signed [TIME_BITS-1:0]   single_at;
      bit                            low_seen;
      logic signed [TIME_BITS-1:0]   low_at;
      bit                            high_seen;
      logic signed [CHARGE_BITS-1:0] charge_acc;
   } wave_state_type;

   logic                      clock     = 1'b0;
   logic                      reset     = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   req_type                   req_data  = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   rsp_type                   rsp_data;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;

   // typed expectation travels with the item it belongs to
   bit      offer_typed = 1'b0;
   rsp_type offer_rsp   = '0;

   // predictor state
   cfg_type         model_cfg;
   wave_state_type  wave;
   logic [31:0]     waves_seen;
   logic [31:0]     hit_waves;
   rsp_type         waveform_summary_q [$];

   pace_type pace = PACE_SLOW_RX;
   int    hold_asked       = 0;
   int    items_sent       = 0;
   int    samples_in       = 0;
   int    results_out      = 0;
   int    csr_writes       = 0;
   int    settings_applied = 0;
   int    blocked_cycles   = 0;
   int    mismatches       = 0;

   dir_row_type dir_rows [$];

   pulse_discriminator_and_charge_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #(CLK_HALF) clock = 1'b1;
      #(CLK_HALF) clock = 1'b0;
   end

   // one line per mismatch, printing capped
   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      if (mismatches < PRINT_LIMIT)
         $display("%0t: mismatch on %s: got %0h, want %0h", $time, what, got, want);
      mismatches++;
   endtask

   // predicts the unit for one sample; returns 1 when a waveform summary is due
   function automatic bit discriminate_sample(input req_type s, output rsp_type r);
      longint t;
      longint v;
      longint acc;
      longint chg_max;
      longint chg_min;
      chg_max = longint'($signed(CHARGE_MAX));
      chg_min = longint'($signed(CHARGE_MIN));
      r = '0;
      t = longint'($signed(s.sample_time));
      v = longint'($signed(s.sample_value)) - longint'($signed(model_cfg.baseline));

      // single level
      if (!wave.single_seen && v <= longint'($signed(model_cfg.single_threshold))) begin
         wave.single_seen = 1'b1;
         wave.single_at   = s.sample_time;
      end
      // arming on low level, then confirm on high level inside the window
      if (!wave.low_seen && v <= longint'($signed(model_cfg.low_threshold))) begin
         wave.low_seen = 1'b1;
         wave.low_at   = s.sample_time;
      end
      if (!wave.high_seen && wave.low_seen
          && v <= longint'($signed(model_cfg.high_threshold))
          && (t - longint'($signed(wave.low_at))) <= longint'(model_cfg.coincidence_window))
         wave.high_seen = 1'b1;

      // gated, clamped charge sum
      if (t >= longint'($signed(model_cfg.gate_start))) begin
         acc = longint'($signed(wave.charge_acc)) + v;
         if (acc > chg_max) acc = chg_max;
         else if (acc < chg_min) acc = chg_min;
         wave.charge_acc = CHARGE_BITS'(acc);
      end

      if (!s.last_sample)
         return 1'b0;

      // end of waveform: summary and clear
      waves_seen = waves_seen + 32'd1;
      if (wave.single_seen)
         hit_waves = hit_waves + 32'd1;
      r.single_hit     = wave.single_seen;
      r.single_time    = wave.single_seen ? wave.single_at : '0;
      r.double_hit     = wave.high_seen;
      r.double_time    = wave.high_seen ? wave.low_at : '0;
      r.charge         = (wave.charge_acc == CHARGE_MIN) ? CHARGE_MAX : -wave.charge_acc;
      r.waveform_count = waves_seen;
      r.hit_count      = hit_waves;
      wave = '{default: '0};
      return 1'b1;
   endfunction

   // table row builders
   function automatic dir_row_type row_sample(input int t, input int v, input bit last);
      dir_row_type row;
      row = '{kind: ROW_SAMPLE, sample: '0, checked: 1'b0, want: '0, csr_idx: '0,
              csr_val: '0};
      row.sample.sample_time  = TIME_BITS'(t);
      row.sample.sample_value = SAMPLE_BITS'(v);
      row.sample.last_sample  = last;
      return row;
   endfunction

   function automatic dir_row_type row_check(input int t, input int v, input bit last,
                                             input bit sh, input int st, input bit dh,
                                             input int dt, input longint q, input int wc,
                                             input int hc);
      dir_row_type row;
      row = row_sample(t, v, last);
      row.checked             = 1'b1;
      row.want.single_hit     = sh;
      row.want.single_time    = TIME_BITS'(st);
      row.want.double_hit     = dh;
      row.want.double_time    = TIME_BITS'(dt);
      row.want.charge         = CHARGE_OUT_BITS'(q);
      row.want.waveform_count = COUNT_BITS'(wc);
      row.want.hit_count      = COUNT_BITS'(hc);
      return row;
   endfunction

   function automatic dir_row_type row_csr(input logic [CSR_INDEX_BITS-1:0] idx,
                                           input logic [CSR_DATA_BITS-1:0] data);
      dir_row_type row;
      row = '{kind: ROW_CSR, sample: '0, checked: 1'b0, want: '0, csr_idx: idx,
              csr_val: data};
      return row;
   endfunction

   // offer one item, idling first at random, and wait until it is taken
   task automatic send_sample(input req_type s, input bit typed, input rsp_type want);
      int idle_pct;
      if (pace == PACE_SLOW_TX) idle_pct = 48;
      else if (pace == PACE_SLOW_RX) idle_pct = 8;
      else idle_pct = 0;
      if (int'($urandom_range(0, 99)) < idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_data    <= s;
      offer_typed <= typed;
      offer_rsp   <= want;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   // sender pauses until every summary has come back or the drain limit runs out, then lets the pipe settle
   task automatic drain_results();
      int waited;
      req_valid <= 1'b0;
      waited = 0;
      do begin
         @(posedge clock);
         waited++;
      end while (waveform_summary_q.size() != 0 && waited < DRAIN_LIMIT);
      if (waveform_summary_q.size() != 0) begin
         report_mismatch("summaries never returned", waveform_summary_q.size(), 0);
         waveform_summary_q.delete();
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // leaves csr_valid high; the caller lowers it after the last write
   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   // one setting per phase: all low, all high, or a plausible random one
   task automatic program_phase(input int p);
      int base;
      int sthr;
      int lthr;
      int hthr;
      int win;
      int gate;
      if (p == 0) begin
         base = -32768; sthr = -32768; lthr = -32768; hthr = -32768;
         win  = 0;
         gate = 32'sh8000_0000;
      end else if (p == 4) begin
         base = 32767; sthr = 32767; lthr = 32767; hthr = 32767;
         win  = 20'hf_ffff;
         gate = 32'sh7fff_ffff;
      end else begin
         base = int'($urandom_range(0, 400)) - 200;
         sthr = -int'($urandom_range(20, 300));
         lthr = -int'($urandom_range(5, 150));
         hthr = -int'($urandom_range(20, 400));
         if ($urandom_range(0, 3) == 0) win = int'($urandom_range(0, 20'hf_ffff));
         else win = int'($urandom_range(0, 20000));
         gate = int'($urandom_range(0, 350000)) - 300000;
      end
      drain_results();
      // unused upper bits carry noise, the unit keeps only the field width
      write_reg(CSR_BASELINE,   {16'($urandom), 16'(base)});
      write_reg(CSR_SINGLE_THR, {16'($urandom), 16'(sthr)});
      write_reg(CSR_LOW_THR,    {16'($urandom), 16'(lthr)});
      write_reg(CSR_HIGH_THR,   {16'($urandom), 16'(hthr)});
      write_reg(CSR_WINDOW,     {12'($urandom), 20'(win)});
      write_reg(CSR_GATE_START, 32'(gate));
      csr_valid <= 1'b0;
      settings_applied++;
   endtask

   // baseline with noise and one dip of random depth and width
   task automatic send_waveform();
      int      len;
      int      dip_at;
      int      dip_width;
      int      dip_depth;
      int      lvl;
      int      t;
      req_type s;
      if ($urandom_range(0, 9) == 0) len = int'($urandom_range(1, 40));
      else len = int'($urandom_range(2, 12));
      dip_at    = int'($urandom_range(0, len - 1));
      dip_width = int'($urandom_range(1, 4));
      dip_depth = int'($urandom_range(0, 600));
      t         = -int'($urandom_range(0, 260000));
      for (int k = 0; k < len; k++) begin
         lvl = int'($signed(model_cfg.baseline)) + int'($urandom_range(0, 40)) - 20;
         if (k >= dip_at && k < dip_at + dip_width)
            lvl = lvl - dip_depth * (dip_width - (k - dip_at)) / dip_width;
         if (lvl > 32767) lvl = 32767;
         if (lvl < -32768) lvl = -32768;
         s.sample_time  = TIME_BITS'(t);
         s.sample_value = SAMPLE_BITS'(lvl);
         s.last_sample  = (k == len - 1);
         send_sample(s, 1'b0, '0);
         // mostly forward in time, now and then a step back
         if ($urandom_range(0, 19) == 0) t = t - int'($urandom_range(0, 20000));
         else t = t + int'($urandom_range(100, 3000));
      end
   endtask

   // scoreboard: config tracking, prediction on accepted items, result checks
   always @(posedge clock) begin : scoreboard
      rsp_type predicted;
      rsp_type want;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            csr_writes++;
            case (csr_index)
               CSR_BASELINE:   model_cfg.baseline           = csr_wdata[SAMPLE_BITS-1:0];
               CSR_SINGLE_THR: model_cfg.single_threshold   = csr_wdata[SAMPLE_BITS-1:0];
               CSR_LOW_THR:    model_cfg.low_threshold      = csr_wdata[SAMPLE_BITS-1:0];
               CSR_HIGH_THR:   model_cfg.high_threshold     = csr_wdata[SAMPLE_BITS-1:0];
               CSR_WINDOW:     model_cfg.coincidence_window = csr_wdata[WINDOW_BITS-1:0];
               CSR_GATE_START: model_cfg.gate_start         = csr_wdata[TIME_BITS-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_stall)
            blocked_cycles++;
         if (req_valid && !req_stall) begin
            samples_in++;
            if (discriminate_sample(req_data, predicted))
               waveform_summary_q.push_back(offer_typed ? offer_rsp : predicted);
         end
         if (rsp_valid && !rsp_stall) begin
            results_out++;
            if (waveform_summary_q.size() == 0) begin
               report_mismatch("summary with none expected", rsp_data.waveform_count, 0);
            end else begin
               want = waveform_summary_q.pop_front();
               if (rsp_data.single_hit !== want.single_hit)
                  report_mismatch("single_hit", rsp_data.single_hit, want.single_hit);
               if (rsp_data.single_time !== want.single_time)
                  report_mismatch("single_time", rsp_data.single_time, want.single_time);
               if (rsp_data.double_hit !== want.double_hit)
                  report_mismatch("double_hit", rsp_data.double_hit, want.double_hit);
               if (rsp_data.double_time !== want.double_time)
                  report_mismatch("double_time", rsp_data.double_time, want.double_time);
               if (rsp_data.charge !== want.charge)
                  report_mismatch("charge", rsp_data.charge, want.charge);
               if (rsp_data.waveform_count !== want.waveform_count)
                  report_mismatch("waveform_count", rsp_data.waveform_count,
                                  want.waveform_count);
               if (rsp_data.hit_count !== want.hit_count)
                  report_mismatch("hit_count", rsp_data.hit_count, want.hit_count);
            end
         end
      end
   end

   // receiver: random stall per pace, plus long hold-offs on request
   initial begin : rsp_side
      int stall_pct;
      int hold_granted;
      hold_granted = 0;
      forever begin
         @(posedge clock);
         if (hold_granted != hold_asked) begin
            hold_granted++;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         if (pace == PACE_SLOW_RX) stall_pct = 48;
         else if (pace == PACE_SLOW_TX) stall_pct = 8;
         else stall_pct = 0;
         rsp_stall <= (int'($urandom_range(0, 99)) < stall_pct);
      end
   end

   // stimulus
   initial begin : stimulus
      int      target;
      bit      paused;
      req_type junk;

      model_cfg = '{BASELINE_RST, SINGLE_THR_RST, LOW_THR_RST, HIGH_THR_RST, WINDOW_RST,
                    GATE_START_RST};
      wave       = '{default: '0};
      waves_seen = '0;
      hit_waves  = '0;

      dir_rows = '{
         // after reset: quiet sample, nothing fires
         row_check(0, 0, 1'b1, 1'b0, 0, 1'b0, 0, 0, 1, 0),
         // most negative sample arms and confirms at once
         row_check(0, -32768, 1'b1, 1'b1, 0, 1'b1, 0, 32768, 2, 1),
         // largest sample at the earliest time, outside the gate
         row_check(32'sh8000_0000, 32767, 1'b1, 1'b0, 0, 1'b0, 0, 0, 3, 1),
         // low crossed, high never reached: no double time
         row_check(32'sh7fff_ffff, -50, 1'b1, 1'b0, 0, 1'b0, 0, 50, 4, 1),
         // ordinary pulse over three samples
         row_sample(100, -40, 1'b0), row_sample(200, -150, 1'b0), row_sample(300, 10, 1'b1),
         // high exactly one window after arming
         row_sample(1000, -40, 1'b0), row_sample(11000, -120, 1'b1),
         // one sample-time unit past the window
         row_sample(1000, -40, 1'b0), row_sample(11001, -120, 1'b1),
         // high sample earlier than the arming time still confirms
         row_sample(5000, -40, 1'b0), row_sample(-300000, -120, 1'b1),
         // high level above low level: high alone does not confirm
         row_csr(CSR_LOW_THR, -200), row_csr(CSR_HIGH_THR, -50),
         row_sample(0, -60, 1'b0), row_sample(10, -250, 1'b0), row_sample(20, 0, 1'b1),
         // writes to unused indexes change nothing
         row_csr(CSR_SPARE_A, 32'h8000_0000), row_csr(CSR_SPARE_B, 32'h0000_7fff),
         row_sample(0, -60, 1'b1),
         // corrected sample extremes
         row_csr(CSR_BASELINE, 32767), row_sample(0, -32768, 1'b1),
         row_csr(CSR_BASELINE, -32768), row_sample(0, 32767, 1'b1),
         // narrowest window, latest gate
         row_csr(CSR_WINDOW, 0), row_csr(CSR_GATE_START, 32'h7fff_ffff),
         row_sample(32'sh7fff_fffe, -32768, 1'b0), row_sample(32'sh7fff_ffff, -32768, 1'b1)
      };

      // reset once
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      foreach (dir_rows[i]) begin
         if (dir_rows[i].kind == ROW_CSR) begin
            drain_results();
            write_reg(dir_rows[i].csr_idx, dir_rows[i].csr_val);
            csr_valid <= 1'b0;
         end else begin
            send_sample(dir_rows[i].sample, dir_rows[i].checked, dir_rows[i].want);
         end
      end

      // random phases, one setting each
      for (int p = 0; p < PHASES; p++) begin
         if (p < 3) pace = PACE_SLOW_RX;
         else if (p < 6) pace = PACE_SLOW_TX;
         else pace = PACE_FULL;
         program_phase(p);
         // receiver holds off while items keep coming, so the unit backs up
         if (p == 6)
            hold_asked++;
         target = items_sent + ITEMS_PER_PHASE;
         paused = 1'b0;
         while (items_sent < target) begin
            if (!paused && items_sent >= target - ITEMS_PER_PHASE / 2) begin
               drain_results();
               paused = 1'b1;
            end
            // mostly whole waveforms, some raw items that break them up
            if ($urandom_range(0, 9) == 0) begin
               junk.sample_time  = $urandom;
               junk.sample_value = SAMPLE_BITS'($urandom);
               junk.last_sample  = 1'($urandom);
               send_sample(junk, 1'b0, '0);
            end else begin
               send_waveform();
            end
         end
         send_waveform();
      end

      drain_results();
      $display("covered %0d samples and %0d waveform summaries under %0d settings",
               samples_in, results_out, settings_applied + 1);
      $display("%0d register writes, input held back for %0d cycles",
               csr_writes, blocked_cycles);
      if (mismatches == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   // watchdog
   initial begin : watchdog
      #(TIMEOUT_CYCLES * 2 * CLK_HALF);
      $display("watchdog expired with %0d summaries outstanding", waveform_summary_q.size());
      $display("Test completed with failures");
      $finish;
   end

endmodule
